### hdl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### hdl/q2e_pkg.sv
package q2e_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned CordicStagesMax = 32;
  localparam int unsigned QuatW           = 16;
  localparam int unsigned AngW            = 16;
  // CORDIC datapath width: |vector| up to ~2^33 after gain
  localparam int unsigned CordW           = 38;
  localparam int unsigned SqrtSteps       = 29;

  typedef logic signed [QuatW-1:0] quat_t;
  typedef logic signed [AngW-1:0]  ang_t;

  typedef struct packed {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
  } quat_in_t;

  typedef struct packed {
    ang_t roll;
    ang_t pitch;
    ang_t yaw;
    logic clamped;
  } euler_out_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;  default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### hdl/q2e_if.sv
interface q2e_quat_if;
  logic               valid;
  logic               ready;
  q2e_pkg::quat_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface q2e_euler_if;
  logic                valid;
  logic                ready;
  q2e_pkg::euler_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/q2e_cordic.sv
`include "assert_macros.svh"
// Vectoring CORDIC, one registered stage per iteration, stalls with en_i.
module q2e_cordic #(
  parameter int unsigned Stages = q2e_pkg::CordicStagesDef,
  parameter int unsigned SideW  = 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic signed [q2e_pkg::CordW-1:0]      x_i,
  input  logic signed [q2e_pkg::CordW-1:0]      y_i,
  input  logic [SideW-1:0]                      side_i,
  output logic [31:0]                           ang_o,
  output logic [SideW-1:0]                      side_o
);
  localparam int unsigned N = (Stages > q2e_pkg::CordicStagesMax) ?
                              q2e_pkg::CordicStagesMax : Stages;
  localparam int unsigned W = q2e_pkg::CordW;

  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic [31:0]         z_q [N+1];
  logic [SideW-1:0]    s_q [N+1];

  logic signed [W-1:0] x0_d, y0_d;
  logic [31:0]         z0_d;

  always_comb begin
    x0_d = x_i;
    y0_d = y_i;
    z0_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d = y_i;
        y0_d = -x_i;
        z0_d = 32'h40000000;
      end else begin
        x0_d = -y_i;
        y0_d = x_i;
        z0_d = 32'hC0000000;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x0_d;
      y_q[0] <= y0_d;
      z_q[0] <= z0_d;
      s_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [W-1:0] x_d, y_d;
    logic [31:0]         z_d;
    always_comb begin
      x_d = x_q[i];
      y_d = y_q[i];
      z_d = z_q[i];
      if (y_q[i] > 0) begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + q2e_pkg::atan_lut(5'(i));
      end else if (y_q[i] < 0) begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - q2e_pkg::atan_lut(5'(i));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1] <= x_d;
        y_q[i+1] <= y_d;
        z_q[i+1] <= z_d;
        s_q[i+1] <= s_q[i];
      end
    end
  end

  assign ang_o  = z_q[N];
  assign side_o = s_q[N];

  logic unused_x;
  assign unused_x = ^{x_q[N], y_q[N]} ^ rst_ni;
endmodule

### hdl/quaternion_to_euler_core.sv
`include "assert_macros.svh"
// Quaternion to ZYX Euler angles (roll, pitch, yaw in binary angle units,
// 32768 = pi). Fully pipelined: one transaction per cycle while out_o is not
// stalled; 3 front stages (products, sums, clamp), 29 square-root stages,
// CORDIC_STAGES+1 CORDIC stages (CORDIC_STAGES capped at 32), 1 output reg.
// Pitch uses a restoring sqrt (one result bit per stage) into its own
// CORDIC; roll/yaw use two more in parallel. A stall freezes the whole pipe.
module quaternion_to_euler_core #(
  parameter int unsigned CORDIC_STAGES = q2e_pkg::CordicStagesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  q2e_quat_if.sink     in_i,
  q2e_euler_if.source  out_o
);
  localparam int unsigned W  = q2e_pkg::CordW;
  localparam int unsigned NC = (CORDIC_STAGES > q2e_pkg::CordicStagesMax) ?
                               q2e_pkg::CordicStagesMax : CORDIC_STAGES;
  localparam int unsigned NS = q2e_pkg::SqrtSteps;
  localparam int unsigned Lat = 3 + NS + NC + 1;

  logic en;
  logic [Lat-1:0] vld_q;
  logic           out_vld_q;
  q2e_pkg::euler_out_t out_q;

  assign en = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_i.valid};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  // Stage 1: products (32-bit signed)
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= in_i.data.w * in_i.data.x;
      yz_q <= in_i.data.y * in_i.data.z;
      xx_q <= in_i.data.x * in_i.data.x;
      yy_q <= in_i.data.y * in_i.data.y;
      wz_q <= in_i.data.w * in_i.data.z;
      xy_q <= in_i.data.x * in_i.data.y;
      zz_q <= in_i.data.z * in_i.data.z;
      wy_q <= in_i.data.w * in_i.data.y;
      zx_q <= in_i.data.z * in_i.data.x;
    end
  end

  // Stage 2: sums
  logic signed [W-1:0] sr_q, cr_q, sy_q, cy_q, sp_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q <= W'((34'(wx_q) + 34'(yz_q)) <<< 1);
      cr_q <= W'(35'sd268435456 - (35'(xx_q) + 35'(yy_q)) * 35'sd2);
      sy_q <= W'((34'(wz_q) + 34'(xy_q)) <<< 1);
      cy_q <= W'(35'sd268435456 - (35'(yy_q) + 35'(zz_q)) * 35'sd2);
      sp_q <= W'((34'(wy_q) - 34'(zx_q)) <<< 1);
    end
  end

  // Stage 3: clamp decision and sqrt operand
  localparam logic signed [W-1:0] One = W'(64'sd268435456);
  logic [1:0]          clamp_q; // {flag, negative}
  logic [56:0]         rad_q;
  logic signed [W-1:0] spd_q;
  logic [27:0]         abs_sp;
  logic [55:0]         sq;
  assign abs_sp = sp_q[W-1] ? 28'(-sp_q) : sp_q[27:0];
  assign sq = 56'(abs_sp) * 56'(abs_sp);
  always_ff @(posedge clk_i) begin
    if (en) begin
      clamp_q <= {(sp_q >= One) || (sp_q <= -One), sp_q[W-1]};
      rad_q   <= 57'(57'h100000000000000 - 57'(sq));
      spd_q   <= sp_q;
    end
  end

  // Restoring square root, one result bit per stage
  logic [56:0]         rem_q [NS+1];
  logic [28:0]         root_q [NS+1];
  logic signed [W-1:0] ssp_q [NS+1];
  logic [1:0]          scl_q [NS+1];
  logic signed [W-1:0] ssr_q [NS+1], scr_q [NS+1], ssy_q [NS+1], scy_q [NS+1];

  always_comb begin
    rem_q[0]  = rad_q;
    root_q[0] = '0;
    ssp_q[0]  = spd_q;
    scl_q[0]  = clamp_q;
  end

  logic signed [W-1:0] sr3_q, cr3_q, sy3_q, cy3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sr3_q <= sr_q; cr3_q <= cr_q; sy3_q <= sy_q; cy3_q <= cy_q;
    end
  end
  always_comb begin
    ssr_q[0] = sr3_q; scr_q[0] = cr3_q; ssy_q[0] = sy3_q; scy_q[0] = cy3_q;
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam int unsigned B = NS - 1 - k;
    logic [58:0] cand;
    logic        take;
    assign cand = ({30'b0, root_q[k]} << (B + 1)) | (59'd1 << (2 * B));
    assign take = {2'b0, rem_q[k]} >= cand;
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k+1]  <= take ? 57'({2'b0, rem_q[k]} - cand) : rem_q[k];
        root_q[k+1] <= take ? (root_q[k] | (29'd1 << B)) : root_q[k];
        ssp_q[k+1]  <= ssp_q[k];
        scl_q[k+1]  <= scl_q[k];
        ssr_q[k+1]  <= ssr_q[k]; scr_q[k+1] <= scr_q[k];
        ssy_q[k+1]  <= ssy_q[k]; scy_q[k+1] <= scy_q[k];
      end
    end
  end

  logic [31:0] ang_r, ang_p, ang_y;
  logic [1:0]  cl_o;
  logic        side_r, side_y;

  q2e_cordic #(.Stages(CORDIC_STAGES), .SideW(1)) u_roll (
    .clk_i, .rst_ni, .en_i(en), .x_i(scr_q[NS]), .y_i(ssr_q[NS]),
    .side_i(1'b0), .ang_o(ang_r), .side_o(side_r)
  );
  q2e_cordic #(.Stages(CORDIC_STAGES), .SideW(2)) u_pitch (
    .clk_i, .rst_ni, .en_i(en), .x_i(W'({1'b0, root_q[NS]})), .y_i(ssp_q[NS]),
    .side_i(scl_q[NS]), .ang_o(ang_p), .side_o(cl_o)
  );
  q2e_cordic #(.Stages(CORDIC_STAGES), .SideW(1)) u_yaw (
    .clk_i, .rst_ni, .en_i(en), .x_i(scy_q[NS]), .y_i(ssy_q[NS]),
    .side_i(1'b0), .ang_o(ang_y), .side_o(side_y)
  );

  logic unused_side;
  assign unused_side = side_r ^ side_y;

  logic [31:0]        ang_pr;
  logic signed [15:0] pitch_d;
  logic signed [16:0] ptr;
  assign ang_pr = ang_p + 32'h8000;
  assign ptr = 17'(signed'(ang_pr[31:16]));
  always_comb begin
    if (cl_o[1]) pitch_d = cl_o[0] ? -16'sd16384 : 16'sd16384;
    else if (ptr > 17'sd16384) pitch_d = 16'sd16384;
    else if (ptr < -17'sd16384) pitch_d = -16'sd16384;
    else pitch_d = ptr[15:0];
  end

  logic [31:0] ang_rr, ang_yr;
  assign ang_rr = ang_r + 32'h8000;
  assign ang_yr = ang_y + 32'h8000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.roll    <= ang_rr[31:16];
      out_q.yaw     <= ang_yr[31:16];
      out_q.pitch   <= pitch_d;
      out_q.clamped <= cl_o[1];
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  logic out_stall, pitch_oor;
  assign out_stall = out_o.valid && !out_o.ready;
  assign pitch_oor = out_o.data.pitch > 16'sd16384 || out_o.data.pitch < -16'sd16384;

  `ASSERT_PROP(a_stall_hold, clk_i, rst_ni, out_stall |=> out_vld_q && $stable(out_q), "stall lost")
  `ASSERT_PROP(a_ready, clk_i, rst_ni, !out_o.valid |-> in_i.ready, "not ready while empty")
  `ASSERT_NEVER(a_pitch_rng, clk_i, rst_ni, out_o.valid && pitch_oor, "pitch out of range")
endmodule
